// File: hdl/pcs_pkg.sv
// Package for the precharge and contactor sequencer: mode codes, register
// indexes, field widths and register reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

  localparam int unsigned TIME_W     = 32;  // millisecond tick
  localparam int unsigned VOLT_W     = 14;  // 0.1 V readings and levels
  localparam int unsigned MS_W       = 16;  // grace and hold times
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MODE_W     = 3;
  // 10 * a 14-bit value fits in 18 bits
  localparam int unsigned PROD_W     = VOLT_W + 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_STARTUP   = 3'd0,
    MODE_IDLE      = 3'd1,
    MODE_PRECHARGE = 3'd2,
    MODE_ACTIVE    = 3'd3,
    MODE_FAULT     = 3'd4
  } mode_t;

  localparam logic [CFG_ADDR_W-1:0] CFG_SDC_CHARGED   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TS_DISCHARGED = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BATT_MIN      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STARTUP_GRACE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_GRACE    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_PRECHARGE_HOLD = 3'd5;

  localparam logic [VOLT_W-1:0] RST_SDC_CHARGED    = 14'd100;
  localparam logic [VOLT_W-1:0] RST_TS_DISCHARGED  = 14'd600;
  localparam logic [VOLT_W-1:0] RST_BATT_MIN       = 14'd1000;
  localparam logic [MS_W-1:0]   RST_STARTUP_GRACE  = 16'd3000;
  localparam logic [MS_W-1:0]   RST_IDLE_GRACE     = 16'd3000;
  localparam logic [MS_W-1:0]   RST_PRECHARGE_HOLD = 16'd3000;

endpackage

`default_nettype wire

// File: hdl/precharge_contactor_sequencer.sv
// Top level of the precharge and contactor sequencer: input register, mode
// state machine, configuration registers and output register.
// Depends on pcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  in_      | input     | in_valid / in_stall  | time, three voltages, three flags
//  out_     | output    | out_valid / out_stall| mode, contactor commands, pulses
//  cfg_     | input     | cfg_we (no wait)     | cfg_addr, cfg_data
//
//  One beat per cycle sustained when nothing stalls; a beat passes through the
//  input register and then the output register, which presents its result on
//  out_. The mode and entry time update in the cycle the beat moves to the
//  output register, so the next beat always sees them. Reset (rst_n low,
//  synchronous) returns the mode to startup, the entry time to zero and the
//  registers to their defaults. A stall on out_ backs up into in_stall once
//  the input register is full.

module precharge_contactor_sequencer (
  input  wire                              clk,
  input  wire                              rst_n,
  // input channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [pcs_pkg::TIME_W-1:0]       in_time_ms,
  input  wire  [pcs_pkg::VOLT_W-1:0]       in_sdc_reserve_voltage,
  input  wire  [pcs_pkg::VOLT_W-1:0]       in_ts_voltage,
  input  wire  [pcs_pkg::VOLT_W-1:0]       in_battery_voltage,
  input  wire                              in_sdc_faulted,
  input  wire                              in_precharge_timed_out,
  input  wire                              in_reset_pressed,
  // result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [pcs_pkg::MODE_W-1:0]       out_mode,
  output logic                             out_air_neg_closed,
  output logic                             out_air_pos_closed,
  output logic                             out_ts_active_flag,
  output logic                             out_precharge_start,
  output logic                             out_timeout_flag_clear,
  output logic                             out_imd_fault_clear,
  output logic                             out_mode_changed,
  // configuration
  input  wire                              cfg_we,
  input  wire  [pcs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [pcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import pcs_pkg::*;

  // configuration registers
  logic [VOLT_W-1:0] sdc_charged_r;
  logic [VOLT_W-1:0] ts_discharged_r;
  logic [VOLT_W-1:0] batt_min_r;
  logic [MS_W-1:0]   startup_grace_r;
  logic [MS_W-1:0]   idle_grace_r;
  logic [MS_W-1:0]   precharge_hold_r;

  // input register
  logic              s1_valid_r;
  logic [TIME_W-1:0] s1_time_r;
  logic [VOLT_W-1:0] s1_reserve_r;
  logic [VOLT_W-1:0] s1_ts_r;
  logic [VOLT_W-1:0] s1_batt_r;
  logic              s1_sdc_fault_r;
  logic              s1_timed_out_r;
  logic              s1_reset_btn_r;

  // sequencer state
  mode_t             mode_r;
  mode_t             mode_nxt;
  logic [TIME_W-1:0] entry_time_r;

  // output register
  logic              out_valid_r;
  logic [MODE_W-1:0] out_mode_r;
  logic              out_air_neg_r;
  logic              out_air_pos_r;
  logic              out_ts_active_r;
  logic              out_pc_start_r;
  logic              out_to_clear_r;
  logic              out_imd_clear_r;
  logic              out_changed_r;

  logic              advance;
  logic              accept;
  logic [TIME_W-1:0] elapsed;
  logic [PROD_W-1:0] ts_x10;
  logic [PROD_W-1:0] batt_x9;
  logic              charged_discharged;
  logic              reached_90pct;
  logic              changed;

  // The input register drains whenever the output register is free or is
  // being taken this cycle.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Configuration writes; unknown indexes drop.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdc_charged_r    <= RST_SDC_CHARGED;
      ts_discharged_r  <= RST_TS_DISCHARGED;
      batt_min_r       <= RST_BATT_MIN;
      startup_grace_r  <= RST_STARTUP_GRACE;
      idle_grace_r     <= RST_IDLE_GRACE;
      precharge_hold_r <= RST_PRECHARGE_HOLD;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SDC_CHARGED:    sdc_charged_r    <= cfg_data[VOLT_W-1:0];
        CFG_TS_DISCHARGED:  ts_discharged_r  <= cfg_data[VOLT_W-1:0];
        CFG_BATT_MIN:       batt_min_r       <= cfg_data[VOLT_W-1:0];
        CFG_STARTUP_GRACE:  startup_grace_r  <= cfg_data[MS_W-1:0];
        CFG_IDLE_GRACE:     idle_grace_r     <= cfg_data[MS_W-1:0];
        CFG_PRECHARGE_HOLD: precharge_hold_r <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: capture a beat, hold it until it advances.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_time_r      <= in_time_ms;
      s1_reserve_r   <= in_sdc_reserve_voltage;
      s1_ts_r        <= in_ts_voltage;
      s1_batt_r      <= in_battery_voltage;
      s1_sdc_fault_r <= in_sdc_faulted;
      s1_timed_out_r <= in_precharge_timed_out;
      s1_reset_btn_r <= in_reset_pressed;
    end
  end

  // ---------------------------------------------------------------------------
  // Mode logic. Elapsed time wraps modulo 2^32, so a backward jump in time
  // reads as a very long wait.
  // ---------------------------------------------------------------------------
  assign elapsed = s1_time_r - entry_time_r;

  // 10*ts and 9*batt by shift and add; exact integer form of the 90% check
  assign ts_x10  = {1'b0, s1_ts_r, 3'b000} + {3'b000, s1_ts_r, 1'b0};
  assign batt_x9 = {1'b0, s1_batt_r, 3'b000} + {4'b0000, s1_batt_r};

  assign charged_discharged = (s1_reserve_r >= sdc_charged_r) &&
                              (s1_ts_r < ts_discharged_r);
  assign reached_90pct      = (s1_ts_r > batt_min_r) && (s1_batt_r > batt_min_r) &&
                              (ts_x10 >= batt_x9);

  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      MODE_STARTUP: begin
        if (elapsed >= {{(TIME_W-MS_W){1'b0}}, startup_grace_r}) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_IDLE: begin
        priority if (charged_discharged) begin
          mode_nxt = MODE_PRECHARGE;
        end else if (s1_sdc_fault_r &&
                     elapsed >= {{(TIME_W-MS_W){1'b0}}, idle_grace_r}) begin
          mode_nxt = MODE_FAULT;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_PRECHARGE: begin
        // nothing is evaluated during the hold
        priority if (elapsed < {{(TIME_W-MS_W){1'b0}}, precharge_hold_r}) begin
          mode_nxt = MODE_PRECHARGE;
        end else if (reached_90pct) begin
          mode_nxt = MODE_ACTIVE;
        end else if (s1_sdc_fault_r || s1_timed_out_r) begin
          mode_nxt = MODE_FAULT;
        end else begin
          mode_nxt = MODE_PRECHARGE;
        end
      end
      MODE_ACTIVE: begin
        if (s1_sdc_fault_r) begin
          mode_nxt = MODE_FAULT;
        end
      end
      MODE_FAULT: begin
        if (s1_reset_btn_r) begin
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        // a corrupted code restarts the sequence
        mode_nxt = MODE_STARTUP;
      end
    endcase
  end

  assign changed = (mode_nxt != mode_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_STARTUP;
      entry_time_r <= '0;
    end else if (advance && changed) begin
      mode_r       <= mode_nxt;
      entry_time_r <= s1_time_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load on advance, hold while stalled.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode_r      <= mode_nxt;
      out_air_neg_r   <= (mode_nxt == MODE_PRECHARGE) || (mode_nxt == MODE_ACTIVE);
      out_air_pos_r   <= (mode_nxt == MODE_ACTIVE);
      out_ts_active_r <= (mode_nxt == MODE_ACTIVE);
      out_pc_start_r  <= changed && (mode_nxt == MODE_PRECHARGE);
      out_to_clear_r  <= changed && (mode_r == MODE_PRECHARGE);
      out_imd_clear_r <= (mode_r == MODE_STARTUP);
      out_changed_r   <= changed;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_mode               = out_mode_r;
  assign out_air_neg_closed     = out_air_neg_r;
  assign out_air_pos_closed     = out_air_pos_r;
  assign out_ts_active_flag     = out_ts_active_r;
  assign out_precharge_start    = out_pc_start_r;
  assign out_timeout_flag_clear = out_to_clear_r;
  assign out_imd_fault_clear    = out_imd_clear_r;
  assign out_mode_changed       = out_changed_r;

`ifndef SYNTH
  // Positive contactor never closes without the negative one.
  a_pos_needs_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_air_pos_closed |-> out_air_neg_closed)
    else $error("positive contactor closed without negative");

  // A precharge start is always a change into precharge.
  a_pc_start_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_precharge_start |->
      out_mode_changed && (out_mode == MODE_PRECHARGE))
    else $error("precharge start without entering precharge");

  // A beat is never taken while the input register is full and holding.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !s1_valid_r || advance)
    else $error("input register overwritten");

  // The mode register moves only when a beat advances.
  a_mode_moves_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(mode_r))
    else $error("mode changed without a beat");
`endif

endmodule

`default_nettype wire
